@@ hdl/wda_pkg.sv @@
`default_nettype none

package wda_pkg;

  // Bucket and statistics counter widths.
  localparam int TOKEN_BITS = 32;
  localparam int STAT_BITS  = 32;

  // Refill sum width: wide enough for the bucket plus a 16-bit refill and a carry.
  localparam int ADD_BITS  = 16;
  localparam int TSUM_BITS = ((TOKEN_BITS > ADD_BITS) ? TOKEN_BITS : ADD_BITS) + 1;

  localparam logic [6:0] SAMPLE_MOD  = 7'd100;
  localparam logic [6:0] SAMPLE_LAST = SAMPLE_MOD - 7'd1;

  // Configuration register indexes.
  localparam logic [2:0] CFG_DISABLE    = 3'd0;
  localparam logic [2:0] CFG_WATERMARK  = 3'd1;
  localparam logic [2:0] CFG_ERROR_LVL  = 3'd2;
  localparam logic [2:0] CFG_LVL_STRAT  = 3'd3;
  localparam logic [2:0] CFG_LVL_SAMPLE = 3'd4;
  localparam logic [2:0] CFG_GLOBAL     = 3'd5;

  // Strategy codes.
  localparam logic [2:0] STRAT_NONE       = 3'd0;
  localparam logic [2:0] STRAT_DROP       = 3'd1;
  localparam logic [2:0] STRAT_SAMPLE     = 3'd2;
  localparam logic [2:0] STRAT_RATE_LIMIT = 3'd3;
  localparam logic [2:0] STRAT_FALLBACK   = 3'd4;
  localparam logic [2:0] STRAT_REORDER    = 3'd5;

  typedef struct packed {
    logic        degrade_off;
    logic [10:0] watermark;
    logic [2:0]  error_level;
    logic [63:0] lvl_strat;
    logic [55:0] lvl_sample;
    logic [13:0] global_entry;
  } cfg_t;

  // Policy outcome for one request, before the stateful strategies resolve.
  typedef struct packed {
    logic       handle;        // request reaches strategy handling
    logic [2:0] strat;
    logic [6:0] rate;
    logic       reorder_drop;  // level below the minimum kept level
  } decision_t;

  typedef struct packed {
    logic        drop;
    logic [2:0]  strat;
    logic [6:0]  rate;
    logic        sample_valid;
    logic [31:0] tokens;
    logic [31:0] degraded;
    logic [31:0] dropped;
  } result_t;

endpackage

`default_nettype wire

@@ hdl/wda_policy.sv @@
`default_nettype none

module wda_policy (
  input  wda_pkg::cfg_t      cfg,
  input  logic               req_type,
  input  logic [2:0]         level,
  input  logic [10:0]        queue_fill,
  output wda_pkg::decision_t dec
);
  import wda_pkg::*;

  logic [7:0] entry;
  logic [5:0] rate_idx;
  logic [2:0] strat;
  logic       keep;
  logic [2:0] min_lvl;
  logic [6:0] rate;

  assign entry    = cfg.lvl_strat[{level, 3'b000} +: 8];
  assign rate_idx = 6'(level) * 6'd7;

  always_comb begin
    if (entry[7]) begin
      strat   = entry[6:4];
      keep    = entry[3];
      min_lvl = entry[2:0];
      rate    = cfg.lvl_sample[rate_idx +: 7];
    end else begin
      strat   = cfg.global_entry[13:11];
      keep    = cfg.global_entry[10];
      min_lvl = cfg.global_entry[9:7];
      rate    = cfg.global_entry[6:0];
    end
  end

  always_comb begin
    dec.strat        = strat;
    dec.rate         = rate;
    dec.reorder_drop = (level < min_lvl);
    dec.handle       = !req_type && !cfg.degrade_off && (strat != STRAT_NONE)
                       && !(keep && (level >= cfg.error_level))
                       && (queue_fill >= cfg.watermark);
  end

endmodule

`default_nettype wire

@@ hdl/wda_counters.sv @@
`default_nettype none

module wda_counters (
  input  logic               clk,
  input  logic               rst,
  input  logic               step,
  input  logic               req_type,
  input  logic [15:0]        token_add,
  input  wda_pkg::decision_t dec,
  output wda_pkg::result_t   res
);
  import wda_pkg::*;

  logic [6:0]            sample_count, sample_count_next;
  logic [TOKEN_BITS-1:0] token_count, token_count_next;
  logic [STAT_BITS-1:0]  degraded_count, degraded_count_next;
  logic [STAT_BITS-1:0]  dropped_count, dropped_count_next;

  logic [TSUM_BITS-1:0]  tsum;
  logic [6:0]            sample_inc;
  logic                  drop;
  logic [63:0]           tokens_wide, degraded_wide, dropped_wide;

  assign tsum       = TSUM_BITS'(token_count) + TSUM_BITS'(token_add);
  assign sample_inc = (sample_count == SAMPLE_LAST) ? 7'd0 : sample_count + 7'd1;

  always_comb begin
    sample_count_next   = sample_count;
    token_count_next    = token_count;
    degraded_count_next = degraded_count;
    dropped_count_next  = dropped_count;
    drop                = 1'b0;

    if (req_type) begin
      // refill saturates at the top of the bucket
      if (tsum > TSUM_BITS'({TOKEN_BITS{1'b1}})) begin
        token_count_next = {TOKEN_BITS{1'b1}};
      end else begin
        token_count_next = tsum[TOKEN_BITS-1:0];
      end
    end else if (dec.handle) begin
      unique case (dec.strat)
        STRAT_DROP: begin
          drop = 1'b1;
        end
        STRAT_SAMPLE: begin
          sample_count_next = sample_inc;
          drop              = (sample_inc >= dec.rate);
        end
        STRAT_RATE_LIMIT: begin
          if (token_count != '0) begin
            token_count_next = token_count - TOKEN_BITS'(1);
          end else begin
            drop = 1'b1;
          end
        end
        STRAT_REORDER: begin
          drop = dec.reorder_drop;
        end
        default: begin
          drop = 1'b0;
        end
      endcase
      degraded_count_next = degraded_count + STAT_BITS'(1);
      if (drop) begin
        dropped_count_next = dropped_count + STAT_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_count   <= '0;
      token_count    <= '0;
      degraded_count <= '0;
      dropped_count  <= '0;
    end else if (step) begin
      sample_count   <= sample_count_next;
      token_count    <= token_count_next;
      degraded_count <= degraded_count_next;
      dropped_count  <= dropped_count_next;
    end
  end

  assign tokens_wide   = 64'(token_count_next);
  assign degraded_wide = 64'(degraded_count_next);
  assign dropped_wide  = 64'(dropped_count_next);

  always_comb begin
    res.drop         = drop;
    res.strat        = dec.handle ? dec.strat : STRAT_NONE;
    res.sample_valid = dec.handle && (dec.strat == STRAT_SAMPLE);
    res.rate         = res.sample_valid ? dec.rate : 7'd0;
    res.tokens       = tokens_wide[31:0];
    res.degraded     = degraded_wide[31:0];
    res.dropped      = dropped_wide[31:0];
  end

endmodule

`default_nettype wire

@@ hdl/watermark_drop_admission.sv @@
`default_nettype none

// Watermark drop admission. Each transfer on the request channel is either a
// log request to judge (req_type 0) or a token refill (req_type 1); every
// transfer yields exactly one result transfer, in order. A request picks its
// level's strategy entry, or the global entry when that one is not valid, and
// is kept when degrading is off, the strategy is none, the level is protected
// as critical, or queue_fill is below the watermark. Otherwise it counts as
// degraded and the strategy decides: drop always drops, sample keeps while a
// mod-100 counter is below the rate, rate limit spends a token or drops,
// reorder drops levels below the minimum; fallback and unknown codes keep.
// One item per clock while results are not stalled. The input register takes
// the request, and the policy, bucket and counter update then land in the
// result register, whose outputs form the result transfer. The result register
// backs up into the input register, so a stalled result stops the request
// side only when both registers are full. Config writes (cfg_wr_en,
// cfg_index, cfg_data) take effect at the next edge, should only be made
// while the block is idle, and ignore indexes 6 and 7.

module watermark_drop_admission (
  input  logic        clk,
  input  logic        rst,

  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data,

  input  logic        req_valid,
  output logic        req_stall,
  input  logic        req_type,
  input  logic [2:0]  level,
  input  logic [10:0] queue_fill,
  input  logic [15:0] token_add,

  output logic        res_valid,
  input  logic        res_stall,
  output logic        drop,
  output logic [2:0]  strategy_out,
  output logic [6:0]  sample_rate_out,
  output logic        sample_valid,
  output logic [31:0] tokens_left,
  output logic [31:0] degraded_total,
  output logic [31:0] dropped_total
);
  import wda_pkg::*;

  cfg_t      cfg;
  decision_t dec;
  result_t   res_next;
  result_t   res;

  // input stage
  logic        s1_valid;
  logic        s1_req_type;
  logic [2:0]  s1_level;
  logic [10:0] s1_queue_fill;
  logic [15:0] s1_token_add;

  logic advance;  // result register can take a new value
  logic step;     // item moves from input stage to result register

  assign advance   = !res_valid || !res_stall;
  assign step      = s1_valid && advance;
  assign req_stall = s1_valid && !advance;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.degrade_off  <= 1'b0;
      cfg.watermark    <= 11'd819;
      cfg.error_level  <= 3'd4;
      cfg.lvl_strat    <= '0;
      cfg.lvl_sample   <= '0;
      cfg.global_entry <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_DISABLE:    cfg.degrade_off  <= cfg_data[0];
        CFG_WATERMARK:  cfg.watermark    <= cfg_data[10:0];
        CFG_ERROR_LVL:  cfg.error_level  <= cfg_data[2:0];
        CFG_LVL_STRAT:  cfg.lvl_strat    <= cfg_data;
        CFG_LVL_SAMPLE: cfg.lvl_sample   <= cfg_data[55:0];
        CFG_GLOBAL:     cfg.global_entry <= cfg_data[13:0];
        default: ;
      endcase
    end
  end

  // input register: loads whenever it is empty or its item moves on
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!req_stall) begin
      s1_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!req_stall && req_valid) begin
      s1_req_type   <= req_type;
      s1_level      <= level;
      s1_queue_fill <= queue_fill;
      s1_token_add  <= token_add;
    end
  end

  wda_policy u_policy (
    .cfg        (cfg),
    .req_type   (s1_req_type),
    .level      (s1_level),
    .queue_fill (s1_queue_fill),
    .dec        (dec)
  );

  wda_counters u_counters (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .req_type  (s1_req_type),
    .token_add (s1_token_add),
    .dec       (dec),
    .res       (res_next)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res <= res_next;
    end
  end

  assign drop            = res.drop;
  assign strategy_out    = res.strat;
  assign sample_rate_out = res.rate;
  assign sample_valid    = res.sample_valid;
  assign tokens_left     = res.tokens;
  assign degraded_total  = res.degraded;
  assign dropped_total   = res.dropped;

endmodule

`default_nettype wire
